// File: src/pixel_to_ground_point_solver_top_defines.svh
// Assertion helpers for the checker file.
`ifndef PIXEL_TO_GROUND_POINT_SOLVER_TOP_DEFINES_SVH
`define PIXEL_TO_GROUND_POINT_SOLVER_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is high.
`define PPGS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PPGS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/ppgs_pkg.sv
package ppgs_pkg;

   // Datapath widths
   localparam int PIX_W    = 16;
   localparam int POS_W    = 32;
   localparam int FOCAL_W  = 20;
   localparam int RTERM_W  = 18;
   localparam int ROW_W    = 3 * RTERM_W;
   localparam int ATERM_W  = 39;
   localparam int SPLIT_W  = 19;
   localparam int PP_W     = 59;
   localparam int PROD_W   = 78;
   localparam int SYS_W    = 79;
   localparam int DZ_W     = 33;
   localparam int CHUNK_W  = 26;
   localparam int SPP_W    = 60;
   localparam int SCALED_W = 112;
   localparam int NUM_W    = 114;
   localparam int MAG_W    = 113;
   localparam int DIV_W    = 80;
   localparam int QUOT_W   = 33;
   localparam int EXT_W    = 35;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2   = 3'd4;

   localparam logic [FOCAL_W-1:0] FOCAL_RST = 20'd16000;
   localparam logic [ROW_W-1:0]   ROW0_RST  = 54'd65536;
   localparam logic [ROW_W-1:0]   ROW1_RST  = 54'd17179869184;
   localparam logic [ROW_W-1:0]   ROW2_RST  = 54'd4503599627370496;

   // Linear system handed from the matrix stages to the scale stages
   typedef struct packed {
      logic signed [SYS_W-1:0] det;
      logic signed [SYS_W-1:0] nx;
      logic signed [SYS_W-1:0] ny;
      logic signed [DZ_W-1:0]  dz;
      logic signed [POS_W-1:0] x0;
      logic signed [POS_W-1:0] y0;
   } ppgs_sys_type;

   // Rounded numerator and divisor for one axis
   typedef struct packed {
      logic signed [NUM_W-1:0] n;
      logic [DIV_W-1:0]        d2;
      logic signed [POS_W-1:0] base;
      logic                    sing;
   } ppgs_frac_type;

   // Quotient for one axis
   typedef struct packed {
      logic [QUOT_W-1:0]       q;
      logic                    ovf;
      logic                    neg;
      logic signed [POS_W-1:0] base;
      logic                    sing;
   } ppgs_quot_type;

   function automatic logic signed [RTERM_W-1:0] rterm(input logic [ROW_W-1:0] row,
                                                       input int col);
      return row[RTERM_W*col +: RTERM_W];
   endfunction

   // Signed 39 x 39 product, upper and lower partial halves
   function automatic logic signed [PP_W-1:0] pp_hi(input logic signed [ATERM_W-1:0] a,
                                                    input logic signed [ATERM_W-1:0] b);
      logic signed [ATERM_W-SPLIT_W-1:0] bh;
      bh = b[ATERM_W-1:SPLIT_W];
      return a * bh;
   endfunction

   function automatic logic signed [PP_W-1:0] pp_lo(input logic signed [ATERM_W-1:0] a,
                                                    input logic signed [ATERM_W-1:0] b);
      logic signed [SPLIT_W:0] bl;
      bl = {1'b0, b[SPLIT_W-1:0]};
      return a * bl;
   endfunction

endpackage

// File: src/ppgs_matrix.sv
module ppgs_matrix
   import ppgs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [PIX_W-1:0] pixel_x,
   input  logic signed [PIX_W-1:0] pixel_y,
   input  logic signed [POS_W-1:0] camera_x,
   input  logic signed [POS_W-1:0] camera_y,
   input  logic signed [POS_W-1:0] camera_z,
   input  logic [FOCAL_W-1:0]      focal,
   input  logic signed [POS_W-1:0] height,
   input  logic [ROW_W-1:0]        row0,
   input  logic [ROW_W-1:0]        row1,
   input  logic [ROW_W-1:0]        row2,
   output logic                    out_valid,
   output ppgs_sys_type            sys
);

   // px*r + f*r' with exact widths
   function automatic logic signed [ATERM_W-1:0] mac(input logic signed [PIX_W-1:0] p,
                                                     input logic signed [RTERM_W-1:0] rp,
                                                     input logic signed [FOCAL_W:0] f,
                                                     input logic signed [RTERM_W-1:0] rf);
      logic signed [PIX_W+RTERM_W-1:0] tp;
      logic signed [ATERM_W-1:0]       tf;
      tp = p * rp;
      tf = f * rf;
      return ATERM_W'(tp) + tf;
   endfunction

   logic signed [FOCAL_W:0] f;
   assign f = $signed({1'b0, focal});

   // Stage 1: collinearity terms
   logic signed [ATERM_W-1:0] a11_ff, a12_ff, a21_ff, a22_ff, b1_ff, b2_ff;
   logic signed [DZ_W-1:0]    dz1_ff;
   logic signed [POS_W-1:0]   x1_ff, y1_ff;
   logic                      v1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a11_ff <= mac(pixel_x, rterm(row0, 2), f, rterm(row0, 0));
         a12_ff <= mac(pixel_x, rterm(row1, 2), f, rterm(row1, 0));
         a21_ff <= mac(pixel_y, rterm(row0, 2), f, rterm(row0, 1));
         a22_ff <= mac(pixel_y, rterm(row1, 2), f, rterm(row1, 1));
         b1_ff  <= mac(pixel_x, rterm(row2, 2), f, rterm(row2, 0));
         b2_ff  <= mac(pixel_y, rterm(row2, 2), f, rterm(row2, 1));
         dz1_ff <= DZ_W'(camera_z) - DZ_W'(height);
         x1_ff  <= camera_x;
         y1_ff  <= camera_y;
      end
   end

   // Stage 2: partial products of the six cross terms
   logic signed [PP_W-1:0]  ph_ff [0:5];
   logic signed [PP_W-1:0]  pl_ff [0:5];
   logic signed [DZ_W-1:0]  dz2_ff;
   logic signed [POS_W-1:0] x2_ff, y2_ff;
   logic                    v2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff[0] <= pp_hi(a11_ff, a22_ff);  pl_ff[0] <= pp_lo(a11_ff, a22_ff);
         ph_ff[1] <= pp_hi(a12_ff, a21_ff);  pl_ff[1] <= pp_lo(a12_ff, a21_ff);
         ph_ff[2] <= pp_hi(b1_ff, a22_ff);   pl_ff[2] <= pp_lo(b1_ff, a22_ff);
         ph_ff[3] <= pp_hi(a12_ff, b2_ff);   pl_ff[3] <= pp_lo(a12_ff, b2_ff);
         ph_ff[4] <= pp_hi(a11_ff, b2_ff);   pl_ff[4] <= pp_lo(a11_ff, b2_ff);
         ph_ff[5] <= pp_hi(a21_ff, b1_ff);   pl_ff[5] <= pp_lo(a21_ff, b1_ff);
         dz2_ff   <= dz1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
      end
   end

   // Stage 3: full products
   logic signed [PROD_W-1:0] pr_ff [0:5];
   logic signed [DZ_W-1:0]   dz3_ff;
   logic signed [POS_W-1:0]  x3_ff, y3_ff;
   logic                     v3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            pr_ff[i] <= (PROD_W'(ph_ff[i]) <<< SPLIT_W) + PROD_W'(pl_ff[i]);
         end
         dz3_ff <= dz2_ff;
         x3_ff  <= x2_ff;
         y3_ff  <= y2_ff;
      end
   end

   // Stage 4: determinant and Cramer numerators
   ppgs_sys_type sys_ff;
   logic         v4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sys_ff.det <= SYS_W'(pr_ff[0]) - SYS_W'(pr_ff[1]);
         sys_ff.nx  <= SYS_W'(pr_ff[2]) - SYS_W'(pr_ff[3]);
         sys_ff.ny  <= SYS_W'(pr_ff[4]) - SYS_W'(pr_ff[5]);
         sys_ff.dz  <= dz3_ff;
         sys_ff.x0  <= x3_ff;
         sys_ff.y0  <= y3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign sys       = sys_ff;

endmodule

// File: src/ppgs_scale.sv
module ppgs_scale
   import ppgs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [SYS_W-1:0] num,
   input  logic signed [SYS_W-1:0] det,
   input  logic signed [DZ_W-1:0]  dz,
   input  logic signed [POS_W-1:0] base,
   output logic                    out_valid,
   output ppgs_frac_type           frac
);

   // Stage 5: num * dz as three partial products
   logic signed [SPP_W-1:0] pp0, pp1, pp2;
   assign pp0 = $signed({1'b0, num[CHUNK_W-1:0]}) * dz;
   assign pp1 = $signed({1'b0, num[2*CHUNK_W-1:CHUNK_W]}) * dz;
   assign pp2 = $signed(num[SYS_W-1:2*CHUNK_W]) * dz;

   logic signed [SPP_W-1:0] pp0_ff, pp1_ff, pp2_ff;
   logic signed [SYS_W-1:0] det5_ff;
   logic signed [POS_W-1:0] base5_ff;
   logic                    v5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff   <= pp0;
         pp1_ff   <= pp1;
         pp2_ff   <= pp2;
         det5_ff  <= det;
         base5_ff <= base;
      end
   end

   // Stage 6: sum partials
   logic signed [SCALED_W-1:0] pr6_ff;
   logic signed [SYS_W-1:0]    det6_ff;
   logic signed [POS_W-1:0]    base6_ff;
   logic                       v6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pr6_ff   <= (SCALED_W'(pp2_ff) <<< (2*CHUNK_W)) + (SCALED_W'(pp1_ff) <<< CHUNK_W)
                     + SCALED_W'(pp0_ff);
         det6_ff  <= det5_ff;
         base6_ff <= base5_ff;
      end
   end

   // Stage 7: fold the determinant sign into the product
   logic signed [SCALED_W-1:0] p7_ff;
   logic [DIV_W-1:0]           d2_7_ff;
   logic                       sing7_ff;
   logic signed [POS_W-1:0]    base7_ff;
   logic                       v7_ff;
   logic [SYS_W-1:0]           dmag;

   assign dmag = det6_ff[SYS_W-1] ? SYS_W'(-det6_ff) : SYS_W'(det6_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p7_ff    <= det6_ff[SYS_W-1] ? -pr6_ff : pr6_ff;
         d2_7_ff  <= {dmag, 1'b0};
         sing7_ff <= (det6_ff == '0);
         base7_ff <= base6_ff;
      end
   end

   // Stage 8: 2p + |det| for round half up
   ppgs_frac_type frac_ff;
   logic          v8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         frac_ff.n    <= (NUM_W'(p7_ff) <<< 1) + NUM_W'(d2_7_ff[DIV_W-1:1]);
         frac_ff.d2   <= d2_7_ff;
         frac_ff.sing <= sing7_ff;
         frac_ff.base <= base7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   assign out_valid = v8_ff;
   assign frac      = frac_ff;

endmodule

// File: src/ppgs_divider.sv
module ppgs_divider
   import ppgs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  ppgs_frac_type frac,
   output logic          out_valid,
   output ppgs_quot_type quot
);

   // Stage 0: magnitude for floor division, overflow check on the top bits
   logic [MAG_W-1:0] mag;
   assign mag = frac.n[NUM_W-1] ? ~frac.n[MAG_W-1:0] : frac.n[MAG_W-1:0];

   logic [DIV_W-1:0]        rem_ff  [0:QUOT_W];
   logic [QUOT_W-1:0]       low_ff  [0:QUOT_W];
   logic [QUOT_W-1:0]       q_ff    [0:QUOT_W];
   logic [DIV_W-1:0]        d2_ff   [0:QUOT_W];
   logic                    ovf_ff  [0:QUOT_W];
   logic                    neg_ff  [0:QUOT_W];
   logic                    sing_ff [0:QUOT_W];
   logic signed [POS_W-1:0] base_ff [0:QUOT_W];
   logic                    v_ff    [0:QUOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= mag[MAG_W-1:QUOT_W];
         low_ff[0]  <= mag[QUOT_W-1:0];
         q_ff[0]    <= '0;
         d2_ff[0]   <= frac.d2;
         ovf_ff[0]  <= (mag[MAG_W-1:QUOT_W] >= frac.d2);
         neg_ff[0]  <= frac.n[NUM_W-1];
         sing_ff[0] <= frac.sing;
         base_ff[0] <= frac.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   // One restoring step per stage, quotient MSB first
   for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
      logic [DIV_W:0] trial;
      logic           fits;
      assign trial = {rem_ff[k-1], low_ff[k-1][QUOT_W-1]};
      assign fits  = (trial >= {1'b0, d2_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? DIV_W'(trial - {1'b0, d2_ff[k-1]}) : trial[DIV_W-1:0];
            low_ff[k]  <= low_ff[k-1] << 1;
            q_ff[k]    <= {q_ff[k-1][QUOT_W-2:0], fits};
            d2_ff[k]   <= d2_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
            base_ff[k] <= base_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[QUOT_W];
   assign quot.q    = q_ff[QUOT_W];
   assign quot.ovf  = ovf_ff[QUOT_W];
   assign quot.neg  = neg_ff[QUOT_W];
   assign quot.base = base_ff[QUOT_W];
   assign quot.sing = sing_ff[QUOT_W];

endmodule

// File: src/pixel_to_ground_point_solver_top.sv
// Pipeline from an accepted req beat to its rsp beat: 4 matrix, 4 scale,
// 34 divider stages and 1 output register.
// Throughput: one beat per cycle; the 33-step pipelined divider sets the depth.
// A stalled rsp beat holds the whole pipeline; bubbles are not compacted.
// Reset (synchronous, high) empties the pipeline and restores the register defaults.
module pixel_to_ground_point_solver_top
   import ppgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // {camera_z, camera_y, camera_x, pixel_y, pixel_x} from bit 0 up
   input  logic [127:0]         req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // {ground_y, ground_x} from bit 0 up: ground_x, ground_y
   output logic [63:0]          rsp_tdata,
   // singular
   output logic                 rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_data
);

   localparam logic signed [EXT_W-1:0] G_MAX = EXT_W'(32'sh7FFF_FFFF);
   localparam logic signed [EXT_W-1:0] G_MIN = -EXT_W'(36'sh8000_0000);

   // Configuration registers
   logic [FOCAL_W-1:0]      focal_ff;
   logic signed [POS_W-1:0] height_ff;
   logic [ROW_W-1:0]        row0_ff, row1_ff, row2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= FOCAL_RST;
         height_ff <= '0;
         row0_ff   <= ROW0_RST;
         row1_ff   <= ROW1_RST;
         row2_ff   <= ROW2_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL:  focal_ff  <= csr_data[FOCAL_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[POS_W-1:0];
            CSR_ROW0:   row0_ff   <= csr_data;
            CSR_ROW1:   row1_ff   <= csr_data;
            CSR_ROW2:   row2_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Global advance: move when the output slot is free or being drained
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   ppgs_sys_type sys;
   logic         sys_valid;

   ppgs_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pixel_x   (req_tdata[15:0]),
      .pixel_y   (req_tdata[31:16]),
      .camera_x  (req_tdata[63:32]),
      .camera_y  (req_tdata[95:64]),
      .camera_z  (req_tdata[127:96]),
      .focal     (focal_ff),
      .height    (height_ff),
      .row0      (row0_ff),
      .row1      (row1_ff),
      .row2      (row2_ff),
      .out_valid (sys_valid),
      .sys       (sys)
   );

   ppgs_frac_type frac_x, frac_y;
   logic          fx_valid, fy_valid;

   ppgs_scale u_scale_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sys_valid),
      .num       (sys.nx),
      .det       (sys.det),
      .dz        (sys.dz),
      .base      (sys.x0),
      .out_valid (fx_valid),
      .frac      (frac_x)
   );

   ppgs_scale u_scale_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sys_valid),
      .num       (sys.ny),
      .det       (sys.det),
      .dz        (sys.dz),
      .base      (sys.y0),
      .out_valid (fy_valid),
      .frac      (frac_y)
   );

   ppgs_quot_type quot_x, quot_y;
   logic          qx_valid, qy_valid;

   ppgs_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fx_valid),
      .frac      (frac_x),
      .out_valid (qx_valid),
      .quot      (quot_x)
   );

   ppgs_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fy_valid),
      .frac      (frac_y),
      .out_valid (qy_valid),
      .quot      (quot_y)
   );

   // Final: restore sign, add camera position, saturate; singular systems give zero
   function automatic logic [POS_W-1:0] finish(input ppgs_quot_type qt);
      logic signed [EXT_W-1:0] s;
      logic signed [EXT_W-1:0] g;
      s = qt.neg ? ~{2'b00, qt.q} : {2'b00, qt.q};
      g = EXT_W'(qt.base) + s;
      if (qt.sing) begin
         return '0;
      end else if (qt.ovf) begin
         return qt.neg ? G_MIN[POS_W-1:0] : G_MAX[POS_W-1:0];
      end else if (g > G_MAX) begin
         return G_MAX[POS_W-1:0];
      end else if (g < G_MIN) begin
         return G_MIN[POS_W-1:0];
      end
      return g[POS_W-1:0];
   endfunction

   logic [POS_W-1:0] gx_ff, gy_ff;
   logic             sing_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff   <= finish(quot_x);
         gy_ff   <= finish(quot_y);
         sing_ff <= quot_x.sing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= qx_valid && qy_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {gy_ff, gx_ff};
   assign rsp_tuser  = sing_ff;

endmodule

// File: src/ppgs_checker.sv
`include "pixel_to_ground_point_solver_top_defines.svh"

module ppgs_checker
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // A held rsp beat keeps its payload
   `PPGS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // Singular systems report a zero ground point
   `PPGS_ASSERT(a_sing_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0, "singular beat with nonzero coordinates")

   // An empty output slot never blocks the input side
   `PPGS_ASSERT(a_no_block, !rsp_tvalid |-> req_tready, "req stalled with empty output")

   // Nothing comes out right after reset
   `PPGS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp beat right after reset")

endmodule

bind pixel_to_ground_point_solver_top ppgs_checker u_ppgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
